// ===== rtl/cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types and constants of the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;

    // fixed field widths of the channels
    localparam int IN_W   = 16;
    localparam int OUT_W  = 36;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int KIND_W = 2;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // input commands
    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_INNER = 2'd1,
        REG_COLS  = 2'd2,
        REG_KINDS = 2'd3
    } reg_idx_t;

    // which pair of parts goes through the multiplier
    typedef enum logic [1:0] {
        MUL_RR = 2'd0,
        MUL_II = 2'd1,
        MUL_RI = 2'd2,
        MUL_IR = 2'd3
    } mul_sel_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  inner;
        logic [DIM_W-1:0]  cols;
        logic [KIND_W-1:0] kinds;
    } cfg_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic     mul_en;
        mul_sel_t sel;
        logic     acc_clear;
        logic     a_cx;
        logic     b_cx;
    } mac_ctl_t;

endpackage

// ===== rtl/cmm_if.sv =====
// ----------------------------------------------------------------------------
// cmm_if
// Valid/ready channels for load/compute commands and product elements.
// ----------------------------------------------------------------------------
interface cmm_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        cmd;
    logic [cmm_pkg::IDX_W-1:0]         row;
    logic [cmm_pkg::IDX_W-1:0]         col;
    logic signed [cmm_pkg::IN_W-1:0]   real_part;
    logic signed [cmm_pkg::IN_W-1:0]   imag_part;

    modport source (output valid, cmd, row, col, real_part, imag_part, input ready);
    modport sink (input valid, cmd, row, col, real_part, imag_part, output ready);
endinterface

interface cmm_out_if;
    logic                              valid;
    logic                              ready;
    logic [cmm_pkg::IDX_W-1:0]         out_row;
    logic [cmm_pkg::IDX_W-1:0]         out_col;
    logic signed [cmm_pkg::OUT_W-1:0]  out_real;
    logic signed [cmm_pkg::OUT_W-1:0]  out_imag;
    logic                              last;

    modport source (output valid, out_row, out_col, out_real, out_imag, last, input ready);
    modport sink (input valid, out_row, out_col, out_real, out_imag, last, output ready);
endinterface

// ===== rtl/cmm_regs.sv =====
// ----------------------------------------------------------------------------
// cmm_regs
// APB configuration registers: matrix dimensions and operand kinds.
// ----------------------------------------------------------------------------
module cmm_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmm_pkg::ADDR_W-1:0]    paddr,
    input  logic [cmm_pkg::DATA_W-1:0]    pwdata,
    output logic [cmm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output cmm_pkg::cfg_t                 cfg
);

    logic [cmm_pkg::DIM_W-1:0]  rows_reg;
    logic [cmm_pkg::DIM_W-1:0]  inner_reg;
    logic [cmm_pkg::DIM_W-1:0]  cols_reg;
    logic [cmm_pkg::KIND_W-1:0] kinds_reg;
    cmm_pkg::reg_idx_t          idx;
    logic                       wr_en;

    assign pready = 1'b1;
    assign idx    = cmm_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= cmm_pkg::DIM_W'(8);
            inner_reg <= cmm_pkg::DIM_W'(8);
            cols_reg  <= cmm_pkg::DIM_W'(8);
            kinds_reg <= cmm_pkg::KIND_W'(3);
        end
        else if (wr_en)
        begin
            unique case (idx)
                cmm_pkg::REG_ROWS:  rows_reg  <= pwdata[cmm_pkg::DIM_W-1:0];
                cmm_pkg::REG_INNER: inner_reg <= pwdata[cmm_pkg::DIM_W-1:0];
                cmm_pkg::REG_COLS:  cols_reg  <= pwdata[cmm_pkg::DIM_W-1:0];
                cmm_pkg::REG_KINDS: kinds_reg <= pwdata[cmm_pkg::KIND_W-1:0];
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            cmm_pkg::REG_ROWS:  prdata = cmm_pkg::DATA_W'(rows_reg);
            cmm_pkg::REG_INNER: prdata = cmm_pkg::DATA_W'(inner_reg);
            cmm_pkg::REG_COLS:  prdata = cmm_pkg::DATA_W'(cols_reg);
            cmm_pkg::REG_KINDS: prdata = cmm_pkg::DATA_W'(kinds_reg);
        endcase
    end

    assign cfg = '{rows: rows_reg, inner: inner_reg, cols: cols_reg, kinds: kinds_reg};

endmodule

// ===== rtl/cmm_store.sv =====
// ----------------------------------------------------------------------------
// cmm_store
// Operand element memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cmm_store
#(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int AW     = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cmm_mac.sv =====
// ----------------------------------------------------------------------------
// cmm_mac
// Shared real multiplier with complex accumulators; one partial product
// per cycle while mul_en is set, accumulated in the cycle after.
// ----------------------------------------------------------------------------
module cmm_mac
#(
    parameter int ELEM_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cmm_pkg::mac_ctl_t                 ctl,
    input  logic [2*ELEM_WIDTH-1:0]           a_data,
    input  logic [2*ELEM_WIDTH-1:0]           b_data,
    output logic signed [cmm_pkg::OUT_W-1:0]  acc_re,
    output logic signed [cmm_pkg::OUT_W-1:0]  acc_im
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0]       a_re, a_im, b_re, b_im;
    logic signed [ELEM_WIDTH-1:0]       mul_x, mul_y;
    logic signed [PROD_W-1:0]           prod_reg;
    logic                               op_valid_reg;
    cmm_pkg::mul_sel_t                  op_sel_reg;
    logic signed [cmm_pkg::OUT_W-1:0]   prod_ext;
    logic signed [cmm_pkg::OUT_W-1:0]   acc_re_reg, acc_re_next;
    logic signed [cmm_pkg::OUT_W-1:0]   acc_im_reg, acc_im_next;

    // operand parts, real operands read as zero imaginary
    assign a_re = signed'(a_data[ELEM_WIDTH-1:0]);
    assign b_re = signed'(b_data[ELEM_WIDTH-1:0]);
    assign a_im = ctl.a_cx ? signed'(a_data[PROD_W-1:ELEM_WIDTH]) : '0;
    assign b_im = ctl.b_cx ? signed'(b_data[PROD_W-1:ELEM_WIDTH]) : '0;

    // multiplier operand select
    always_comb
    begin
        unique case (ctl.sel)
            cmm_pkg::MUL_RR: begin mul_x = a_re; mul_y = b_re; end
            cmm_pkg::MUL_II: begin mul_x = a_im; mul_y = b_im; end
            cmm_pkg::MUL_RI: begin mul_x = a_re; mul_y = b_im; end
            cmm_pkg::MUL_IR: begin mul_x = a_im; mul_y = b_re; end
        endcase
    end

    // product register and the op it feeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            op_sel_reg   <= cmm_pkg::MUL_RR;
        end
        else
        begin
            op_valid_reg <= ctl.mul_en;
            op_sel_reg   <= ctl.sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= mul_x * mul_y;
        end
    end

    // accumulate, wrapping to the output width
    assign prod_ext = cmm_pkg::OUT_W'(prod_reg);

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl.acc_clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (op_valid_reg)
        begin
            unique case (op_sel_reg)
                cmm_pkg::MUL_RR: acc_re_next = acc_re_reg + prod_ext;
                cmm_pkg::MUL_II: acc_re_next = acc_re_reg - prod_ext;
                cmm_pkg::MUL_RI: acc_im_next = acc_im_reg + prod_ext;
                cmm_pkg::MUL_IR: acc_im_next = acc_im_reg + prod_ext;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// ===== rtl/complex_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// complex_matrix_multiply
// Complex matrix product R = A * B over two operand stores, sequenced over
// one shared multiplier.
// ----------------------------------------------------------------------------
// A load command (A or B element) writes one store entry when its row and
// column are below MAX_DIM. A compute command emits the product in row-major
// order, one beat per element, with last on the final one. Each element
// takes, per inner term, one store read step and four real products through
// the single multiplier, plus a drain and an emit step; the emit step waits
// on any output stall, and the input is not ready until the run is done.
// Store entries must be written before a run reads them.
module complex_matrix_multiply
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    cmm_in_if.sink                        item,
    cmm_out_if.source                     result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmm_pkg::ADDR_W-1:0]    paddr,
    input  logic [cmm_pkg::DATA_W-1:0]    pwdata,
    output logic [cmm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W  = 2 * ELEM_WIDTH;
    localparam int IW     = cmm_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL_RR,
        S_MUL_II,
        S_MUL_RI,
        S_MUL_IR,
        S_DRAIN,
        S_EMIT
    } state_t;

    cmm_pkg::cfg_t              cfg;
    cmm_pkg::mac_ctl_t          ctl;
    cmm_pkg::cmd_t              cmd;

    state_t                     state_reg;
    logic [IW-1:0]              i_reg, j_reg, k_reg;
    logic [IW-1:0]              lim_i_reg, lim_j_reg, lim_k_reg;
    logic [cmm_pkg::KIND_W-1:0] kinds_reg;
    logic [IW-1:0]              lim_i_next, lim_j_next, lim_k_next;

    logic                       out_valid_reg;
    logic [IW-1:0]              out_row_reg, out_col_reg;
    logic signed [cmm_pkg::OUT_W-1:0] out_real_reg, out_imag_reg;
    logic                       out_last_reg;

    logic                       accept, start, load_ok, emit, run_last;
    logic                       wr_a, wr_b;
    logic [AW-1:0]              wr_addr, rd_a_addr, rd_b_addr;
    logic [ENT_W-1:0]           wr_data, a_data, b_data;
    logic signed [ELEM_WIDTH-1:0] elem_re, elem_im;
    logic signed [cmm_pkg::OUT_W-1:0] acc_re, acc_im;

    // configuration registers
    cmm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input decode
    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign cmd        = cmm_pkg::cmd_t'(item.cmd);
    assign start      = accept && (cmd == cmm_pkg::CMD_COMPUTE);
    assign load_ok    = ({1'b0, item.row} < (IW + 1)'(MAX_DIM))
                     && ({1'b0, item.col} < (IW + 1)'(MAX_DIM));
    assign wr_a       = accept && load_ok && (cmd == cmm_pkg::CMD_LOAD_A);
    assign wr_b       = accept && load_ok && (cmd == cmm_pkg::CMD_LOAD_B);

    // element conversion to the stored width
    assign elem_re = ELEM_WIDTH'(item.real_part);
    assign elem_im = ELEM_WIDTH'(item.imag_part);
    assign wr_data = {elem_im, elem_re};
    assign wr_addr = AW'(AW'(item.row) * AW'(MAX_DIM) + AW'(item.col));

    // store read addresses: A(i,j) and B(j,k)
    assign rd_a_addr = AW'(AW'(i_reg) * AW'(MAX_DIM) + AW'(j_reg));
    assign rd_b_addr = AW'(AW'(j_reg) * AW'(MAX_DIM) + AW'(k_reg));

    cmm_store #(.DEPTH(DEPTH), .WIDTH(ENT_W), .AW(AW)) u_store_a
    (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_READ),
        .rd_addr (rd_a_addr),
        .rd_data (a_data)
    );

    cmm_store #(.DEPTH(DEPTH), .WIDTH(ENT_W), .AW(AW)) u_store_b
    (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_READ),
        .rd_addr (rd_b_addr),
        .rd_data (b_data)
    );

    // dimension clamp to last index
    always_comb
    begin
        priority if (cfg.rows == '0)
            lim_i_next = '0;
        else if (cfg.rows > cmm_pkg::DIM_W'(MAX_DIM))
            lim_i_next = IW'(MAX_DIM - 1);
        else
            lim_i_next = IW'(cfg.rows - 1'b1);

        priority if (cfg.inner == '0)
            lim_j_next = '0;
        else if (cfg.inner > cmm_pkg::DIM_W'(MAX_DIM))
            lim_j_next = IW'(MAX_DIM - 1);
        else
            lim_j_next = IW'(cfg.inner - 1'b1);

        priority if (cfg.cols == '0)
            lim_k_next = '0;
        else if (cfg.cols > cmm_pkg::DIM_W'(MAX_DIM))
            lim_k_next = IW'(MAX_DIM - 1);
        else
            lim_k_next = IW'(cfg.cols - 1'b1);
    end

    // emit when the output register is free or being taken
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);
    assign run_last = (i_reg == lim_i_reg) && (k_reg == lim_k_reg);

    // multiply-accumulate control
    always_comb
    begin
        ctl.mul_en    = 1'b0;
        ctl.sel       = cmm_pkg::MUL_RR;
        ctl.acc_clear = start || emit;
        ctl.a_cx      = kinds_reg[0];
        ctl.b_cx      = kinds_reg[1];
        unique case (state_reg)
            S_MUL_RR: begin ctl.mul_en = 1'b1; ctl.sel = cmm_pkg::MUL_RR; end
            S_MUL_II: begin ctl.mul_en = 1'b1; ctl.sel = cmm_pkg::MUL_II; end
            S_MUL_RI: begin ctl.mul_en = 1'b1; ctl.sel = cmm_pkg::MUL_RI; end
            S_MUL_IR: begin ctl.mul_en = 1'b1; ctl.sel = cmm_pkg::MUL_IR; end
            default:  ctl.mul_en = 1'b0;
        endcase
    end

    cmm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .a_data (a_data),
        .b_data (b_data),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            lim_i_reg     <= '0;
            lim_j_reg     <= '0;
            lim_k_reg     <= '0;
            kinds_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_real_reg  <= '0;
            out_imag_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // output beat: loaded by emit, dropped once taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        lim_i_reg <= lim_i_next;
                        lim_j_reg <= lim_j_next;
                        lim_k_reg <= lim_k_next;
                        kinds_reg <= cfg.kinds;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:   state_reg <= S_MUL_RR;
                S_MUL_RR: state_reg <= S_MUL_II;
                S_MUL_II: state_reg <= S_MUL_RI;
                S_MUL_RI: state_reg <= S_MUL_IR;
                S_MUL_IR:
                begin
                    if (j_reg == lim_j_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_DRAIN:  state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (emit)
                    begin
                        out_row_reg   <= i_reg;
                        out_col_reg   <= k_reg;
                        out_real_reg  <= acc_re;
                        out_imag_reg  <= acc_im;
                        out_last_reg  <= run_last;
                        j_reg         <= '0;
                        if (k_reg == lim_k_reg)
                        begin
                            k_reg <= '0;
                            if (i_reg == lim_i_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_READ;
                            end
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // result channel
    assign result.valid    = out_valid_reg;
    assign result.out_row  = out_row_reg;
    assign result.out_col  = out_col_reg;
    assign result.out_real = out_real_reg;
    assign result.out_imag = out_imag_reg;
    assign result.last     = out_last_reg;

    // a new result beat only comes out of the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result beat raised outside emit");

    // loop counters stay inside the latched dimensions during a run
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg <= lim_i_reg && j_reg <= lim_j_reg
                                   && k_reg <= lim_k_reg))
        else $error("loop counter beyond dimension");

    // the final element ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && run_last) |=> (state_reg == S_IDLE && out_last_reg))
        else $error("run did not end on last element");

    // an emit, which clears the accumulators, only follows a drain or a stalled emit
    a_clear_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> ($past(state_reg) == S_DRAIN || $past(state_reg) == S_EMIT))
        else $error("emit without drain");

endmodule
